// File: design/pqsa_pkg.sv
// Package for the sorted-array priority queue.
// Holds the entry and control types and the status and request codes.
// No dependencies.
package pqsa_pkg;

  localparam int VALUE_W  = 32;
  localparam int PRI_W    = 8;
  localparam int LEVEL_W  = 5;
  localparam int STATUS_W = 2;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Request kinds
  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_t;

  // One stored entry
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [PRI_W-1:0]   pri;
  } entry_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctl_t;

endpackage

// File: design/pqsa_cell.sv
// One slot of the sorted-array priority queue.
// Compares its entry with the incoming one and shifts toward either neighbor.
// Depends on pqsa_pkg.
module pqsa_cell (
  input  logic               clk,
  input  pqsa_pkg::cell_ctl_t ctl,
  input  pqsa_pkg::entry_t   new_entry,
  input  pqsa_pkg::entry_t   left_entry,
  input  logic               left_go,
  input  pqsa_pkg::entry_t   right_entry,
  input  logic               valid,
  output logic               go,
  output pqsa_pkg::entry_t   entry
);

  // Slot moves on an enqueue when empty or holding strictly lower priority
  assign go = !valid || (entry.pri < new_entry.pri);

  // Insert point takes the new entry, slots behind it take the left neighbor;
  // dequeue pulls everything one slot toward the head
  always_ff @(posedge clk) begin
    if (ctl.enq) begin
      if (go) begin
        entry <= left_go ? left_entry : new_entry;
      end
    end else if (ctl.deq) begin
      entry <= right_entry;
    end
  end

endmodule

// File: design/priority_queue_sorted_array.sv
// Sorted-array priority queue, top level: a row of pqsa_cell slots plus
// the entry counter and the result register. Depends on pqsa_pkg, pqsa_cell.
//
// Usage:
//   Requests arrive on the s_axis channel: tuser[0] selects enqueue (0) or
//   dequeue (1); tdata carries the value and priority of an enqueue.
//   Each request gives exactly one result on the m_axis channel: tuser holds
//   the status (ok, full on enqueue, empty on dequeue), tdata the dequeued
//   value and priority (zero otherwise) and the entry count after the request.
//   Entries of higher priority leave first; equal priorities leave in
//   arrival order. Enqueue into a full queue or dequeue from an empty one
//   leaves the contents unchanged.
//   The result register is loaded on the request transaction, so the result is
//   valid in the cycle after it. All slots compare and shift in parallel: one
//   request per cycle is taken, the single result register setting that rate.
//   Reset empties the queue and drops any pending result. While the receiver
//   stalls, the held result stays put and a new request is taken only in a
//   cycle where that result is consumed.
module priority_queue_sorted_array #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] in_value, [39:32] in_priority
  input  logic [0:0]  s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] out_value, [39:32] out_priority,
                                      // [44:40] level, [47:45] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                            accept;
  pqsa_pkg::req_t                  req;
  logic                            full;
  logic                            empty;
  pqsa_pkg::cell_ctl_t             ctl;
  pqsa_pkg::entry_t                new_entry;
  pqsa_pkg::entry_t                entries [DEPTH];
  logic [DEPTH-1:0]                gos;
  logic [CNT_W-1:0]                count;
  logic [CNT_W-1:0]                count_next;
  pqsa_pkg::status_t               status_next;

  pqsa_pkg::status_t               out_status;
  logic [pqsa_pkg::VALUE_W-1:0]    out_value;
  logic [pqsa_pkg::PRI_W-1:0]      out_priority;
  logic [pqsa_pkg::LEVEL_W-1:0]    out_level;

  // Handshake: result register frees up when empty or being consumed
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign req           = pqsa_pkg::req_t'(s_axis_tuser[0]);
  assign new_entry.value = s_axis_tdata[31:0];
  assign new_entry.pri   = s_axis_tdata[39:32];

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  // Command decode and counter update
  always_comb begin
    ctl         = '0;
    count_next  = count;
    status_next = pqsa_pkg::ST_OK;
    if (accept) begin
      case (req)
        pqsa_pkg::REQ_ENQ: begin
          if (full) begin
            status_next = pqsa_pkg::ST_FULL;
          end else begin
            ctl.enq    = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
        pqsa_pkg::REQ_DEQ: begin
          if (empty) begin
            status_next = pqsa_pkg::ST_EMPTY;
          end else begin
            ctl.deq    = 1'b1;
            count_next = count - CNT_W'(1);
          end
        end
        default: begin
          status_next = pqsa_pkg::ST_OK;
        end
      endcase
    end
  end

  // Row of slots, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             cell_valid;
    pqsa_pkg::entry_t left_entry;
    pqsa_pkg::entry_t right_entry;
    logic             left_go;

    assign cell_valid = (count > CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_entry = new_entry;
      assign left_go    = 1'b0;
    end else begin : g_body
      assign left_entry = entries[i-1];
      assign left_go    = gos[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    pqsa_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .left_go     (left_go),
      .right_entry (right_entry),
      .valid       (cell_valid),
      .go          (gos[i]),
      .entry       (entries[i])
    );
  end

  // Entry counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status_next;
      out_level  <= pqsa_pkg::LEVEL_W'(count_next);
      if (ctl.deq) begin
        out_value    <= entries[0].value;
        out_priority <= entries[0].pri;
      end else begin
        out_value    <= '0;
        out_priority <= '0;
      end
    end
  end

  assign m_axis_tdata = {3'b000, out_level, out_priority, out_value};
  assign m_axis_tuser = out_status;

endmodule

// File: tb/pqsa_result_check.sv
// Result checker for the sorted-array priority queue testbench.
// Watches both stream channels, predicts each result and compares it.
// Depends on pqsa_pkg.
`timescale 1ns / 100ps

module pqsa_result_check #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] in_value, [39:32] in_priority
  input  logic [0:0]  s_axis_tuser,   // [0] req_type
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // [31:0] out_value, [39:32] out_priority,
                                      // [44:40] level, [47:45] zero
  input  logic [1:0]  m_axis_tuser,   // [1:0] status
  output int unsigned error_count,
  output int unsigned outstanding
);

  typedef struct packed {
    pqsa_pkg::status_t                 status;
    logic [pqsa_pkg::VALUE_W-1:0]      value;
    logic [pqsa_pkg::PRI_W-1:0]        pri;
    logic [pqsa_pkg::LEVEL_W-1:0]      level;
  } result_t;

  // Shadow copy of the queue contents, head at slot 0
  pqsa_pkg::entry_t slot_entry [DEPTH];
  int unsigned      stored_count;
  result_t          expected_q [$];

  // Apply one request to the shadow queue and return its result
  function automatic result_t serve_request(input pqsa_pkg::req_t kind,
                                            input logic [31:0] val,
                                            input logic [7:0] pri);
    result_t     res;
    int unsigned pos;
    res = '0;
    res.status = pqsa_pkg::ST_OK;
    if (kind == pqsa_pkg::REQ_ENQ) begin
      if (stored_count >= DEPTH) begin
        res.status = pqsa_pkg::ST_FULL;
      end else begin
        // new entry goes behind every entry of equal or higher priority
        pos = 0;
        while (pos < stored_count && slot_entry[pos].pri >= pri) pos++;
        for (int k = stored_count; k > pos; k--) slot_entry[k] = slot_entry[k-1];
        slot_entry[pos].value = val;
        slot_entry[pos].pri   = pri;
        stored_count++;
      end
    end else begin
      if (stored_count == 0) begin
        res.status = pqsa_pkg::ST_EMPTY;
      end else begin
        res.value = slot_entry[0].value;
        res.pri   = slot_entry[0].pri;
        for (int k = 1; k < stored_count; k++) slot_entry[k-1] = slot_entry[k];
        stored_count--;
      end
    end
    res.level = pqsa_pkg::LEVEL_W'(stored_count);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Compare the result transaction first: it belongs to an earlier request
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      stored_count = 0;
      expected_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction: tdata 0x%0h, tuser 0x%0h",
                 m_axis_tdata, m_axis_tuser);
          error_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", 32'(want.status), 32'(m_axis_tuser));
          check_field("out_value", want.value, m_axis_tdata[31:0]);
          check_field("out_priority", 32'(want.pri), 32'(m_axis_tdata[39:32]));
          check_field("level", 32'(want.level), 32'(m_axis_tdata[44:40]));
          check_field("tdata pad", 32'd0, 32'(m_axis_tdata[47:45]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(serve_request(pqsa_pkg::req_t'(s_axis_tuser[0]),
                                           s_axis_tdata[31:0], s_axis_tdata[39:32]));
    end
    outstanding = expected_q.size();
  end

endmodule

// File: tb/priority_queue_sorted_array_tb.sv
// Testbench top for the sorted-array priority queue: clock, reset, request
// stimulus, receiver stalls, watchdog and verdict.
// Depends on pqsa_pkg, priority_queue_sorted_array and pqsa_result_check.
`timescale 1ns / 100ps

module priority_queue_sorted_array_tb;

  localparam int DEPTH       = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_ITEMS  = 700;

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;   // [31:0] in_value, [39:32] in_priority
  logic [0:0]  s_axis_tuser  = '0;   // [0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // [31:0] out_value, [39:32] out_priority,
                                     // [44:40] level, [47:45] zero
  logic [1:0]  m_axis_tuser;         // [1:0] status

  int unsigned error_count;
  int unsigned outstanding;

  // Idle burst chances in percent per transaction / per cycle
  int unsigned tx_rate       = 0;
  int unsigned rx_rate       = 0;
  int unsigned rx_hold_cycles = 0;
  int unsigned quiet_cycles  = 0;

  priority_queue_sorted_array #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  pqsa_result_check #(
    .DEPTH(DEPTH)
  ) u_result_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .error_count   (error_count),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Values lean toward the sign and all-ones corners
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Narrow bands at both ends make ties common
  function automatic logic [7:0] pick_priority();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 3));
      1:       return 8'(255 - $urandom_range(0, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic send_req(input pqsa_pkg::req_t kind, input logic [31:0] val,
                          input logic [7:0] pri);
    if (tx_rate != 0 && $urandom_range(0, 99) < tx_rate) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pri, val};
    s_axis_tuser  <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver: random stall bursts plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (rx_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        stall_left = rx_hold_cycles - 1;
        rx_hold_cycles = 0;
      end else if (rx_rate != 0 && $urandom_range(0, 99) < rx_rate) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(1, 19) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
      @(negedge clk);
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("priority_queue_sorted_array test failed");
      $finish;
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned    sent;
    int unsigned    seg_len;
    int unsigned    enq_pct;
    pqsa_pkg::req_t kind;

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty dequeue, corner values, ties, fill to full, full enqueue
    tx_rate = 20;
    rx_rate = 10;
    send_req(pqsa_pkg::REQ_DEQ, 32'h1234_5678, 8'hFF);
    send_req(pqsa_pkg::REQ_ENQ, 32'h8000_0000, 8'd0);
    send_req(pqsa_pkg::REQ_ENQ, 32'h7FFF_FFFF, 8'd255);
    send_req(pqsa_pkg::REQ_ENQ, 32'hFFFF_FFFF, 8'd255);
    send_req(pqsa_pkg::REQ_ENQ, 32'h0000_0000, 8'd128);
    for (int i = 0; i < DEPTH - 4; i++)
      send_req(pqsa_pkg::REQ_ENQ, 32'h0101_0101 * i,
               (i % 3 == 0) ? 8'd255 : 8'(i * 21));
    send_req(pqsa_pkg::REQ_ENQ, 32'hDEAD_BEEF, 8'd255);
    send_req(pqsa_pkg::REQ_ENQ, 32'h5555_AAAA, 8'd0);
    repeat (5) send_req(pqsa_pkg::REQ_DEQ, $urandom, 8'($urandom));

    // Random: segments with a drifting enqueue share sweep the fill level
    sent = 0;
    while (sent < RAND_ITEMS) begin
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(0, 4))
        0:       enq_pct = 15;
        1:       enq_pct = 35;
        2:       enq_pct = 50;
        3:       enq_pct = 65;
        default: enq_pct = 85;
      endcase
      if (sent == 0) begin
        // receiver holds off while requests keep coming back to back
        tx_rate = 0;
        rx_hold_cycles = HOLD_CYCLES;
      end else if (sent >= RAND_ITEMS - 100) begin
        tx_rate = 0;
        rx_rate = 0;
      end else begin
        tx_rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        rx_rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end
      for (int j = 0; j < seg_len && sent < RAND_ITEMS; j++) begin
        kind = ($urandom_range(0, 99) < enq_pct) ? pqsa_pkg::REQ_ENQ : pqsa_pkg::REQ_DEQ;
        send_req(kind, pick_value(), pick_priority());
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then allow the registered result to settle
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (error_count == 0 && outstanding == 0)
      $display("priority_queue_sorted_array test passed");
    else
      $display("priority_queue_sorted_array test failed");
    $finish;
  end

endmodule
